>>> hdl/vna_pkg.sv
// shared types, sizes, opcodes and helpers for the vertex normal accumulator
package vna_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = 10;
    localparam int ACC_BITS     = 40;
    localparam int POS_W        = 16;
    localparam int CROSS_W      = 2 * (POS_W + 1) + 1;
    localparam int NRM_W        = 16;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // one stored vertex position
    typedef struct packed {
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } t_pos;

    // one accumulator entry
    typedef struct packed {
        logic signed [ACC_BITS-1:0] z;
        logic signed [ACC_BITS-1:0] y;
        logic signed [ACC_BITS-1:0] x;
    } t_acc;

    // normalized result handed from the normalizer to the top level
    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic                    deg;
    } t_norm_res;

    // index range check
    function automatic logic idx_bad(input logic [IDX_W-1:0] idx);
        idx_bad = ({1'b0, idx} >= (IDX_W + 1)'(MAX_VERTICES));
    endfunction

    // saturating add of a face normal component into an accumulator
    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] acc,
        input logic signed [CROSS_W-1:0]  c
    );
        logic signed [ACC_BITS:0] sum;
        sum = {acc[ACC_BITS-1], acc} + (ACC_BITS + 1)'(c);
        if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
            sat_add = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                    : {1'b0, {(ACC_BITS-1){1'b1}}};
        end else begin
            sat_add = sum[ACC_BITS-1:0];
        end
    endfunction

endpackage

>>> hdl/vertex_normal_accumulator.sv
// top level: area-weighted vertex normal accumulator with memory-held state
//
// Input channel (i_in_valid / o_in_ready) takes one beat per item: load a
// vertex position, add a triangle, or read a vertex normal. Output channel
// (o_out_valid / i_out_ready) returns one beat for a read or for any item
// with an out-of-range index; loads and triangles give no beat otherwise.
// Positions live in one ram, the three accumulators of each vertex in a
// second ram; each triangle corner is a read-modify-write on that ram.
// A triangle takes three position reads, one multiply stage, one subtract
// stage, then a read and a write per corner. A read of a zero sum skips the
// normalizer loops; otherwise scaling shifts one bit a cycle, the square
// root gives one digit a cycle and each of three divides one quotient bit a cycle.
// After reset the accumulator ram is cleared one entry a cycle, with
// o_in_ready low. A result waits in the output register while the
// receiver stalls; the next item is still taken, and a second result
// holds the block until the first beat is gone.
module vertex_normal_accumulator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_op,
    input  logic [vna_pkg::IDX_W-1:0]          i_vertex_index,
    input  logic signed [vna_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [vna_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [vna_pkg::POS_W-1:0]   i_pos_z,
    input  logic [vna_pkg::IDX_W-1:0]          i_corner_a,
    input  logic [vna_pkg::IDX_W-1:0]          i_corner_b,
    input  logic [vna_pkg::IDX_W-1:0]          i_corner_c,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [vna_pkg::NRM_W-1:0]   o_normal_x,
    output logic signed [vna_pkg::NRM_W-1:0]   o_normal_y,
    output logic signed [vna_pkg::NRM_W-1:0]   o_normal_z,
    output logic                               o_degenerate,
    output logic                               o_index_error
);

    localparam int IW = vna_pkg::IDX_W;
    localparam int EW = vna_pkg::POS_W + 1;
    localparam int PW = 2 * EW;
    localparam int CW = vna_pkg::CROSS_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PA    = 4'd2;
    localparam logic [3:0] S_PB    = 4'd3;
    localparam logic [3:0] S_PC    = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_CROSS = 4'd6;
    localparam logic [3:0] S_ARD   = 4'd7;
    localparam logic [3:0] S_AWR   = 4'd8;
    localparam logic [3:0] S_NRD   = 4'd9;
    localparam logic [3:0] S_NST   = 4'd10;
    localparam logic [3:0] S_NWAIT = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]             r_state;
    logic [IW-1:0]          r_clr_idx;
    logic [IW-1:0]          r_vi, r_ca, r_cb, r_cc;
    vna_pkg::t_pos          r_pa, r_pb;
    logic signed [PW-1:0]   r_prod [6];
    logic signed [CW-1:0]   r_cx, r_cy, r_cz;
    logic [1:0]             r_k;
    vna_pkg::t_norm_res     r_res;
    logic                   r_err;
    logic                   r_out_valid;
    vna_pkg::t_norm_res     r_out;
    logic                   r_out_err;

    logic                   w_accept;
    logic                   w_in_err;
    logic                   w_out_free;
    logic                   w_pos_we;
    logic [IW-1:0]          w_pos_raddr;
    vna_pkg::t_pos          w_pos_wdata, w_pos_rdata;
    logic                   w_acc_we;
    logic [IW-1:0]          w_acc_waddr, w_acc_raddr, w_corner;
    vna_pkg::t_acc          w_acc_wdata, w_acc_rdata, w_acc_sum;
    logic signed [EW-1:0]   w_e1x, w_e1y, w_e1z, w_e2x, w_e2y, w_e2z;
    logic                   w_norm_done;
    vna_pkg::t_norm_res     w_norm_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // index check for the incoming item
    always_comb begin
        case (i_op)
            vna_pkg::OP_LOAD, vna_pkg::OP_READ: w_in_err = vna_pkg::idx_bad(i_vertex_index);
            vna_pkg::OP_TRI: w_in_err = vna_pkg::idx_bad(i_corner_a)
                                     || vna_pkg::idx_bad(i_corner_b)
                                     || vna_pkg::idx_bad(i_corner_c);
            default: w_in_err = 1'b0;
        endcase
    end

    // corner under read-modify-write
    always_comb begin
        case (r_k)
            2'd0:    w_corner = r_ca;
            2'd1:    w_corner = r_cb;
            default: w_corner = r_cc;
        endcase
    end

    // position ram ports
    assign w_pos_we    = w_accept && (i_op == vna_pkg::OP_LOAD) && !w_in_err;
    assign w_pos_wdata = '{z: i_pos_z, y: i_pos_y, x: i_pos_x};
    always_comb begin
        case (r_state)
            S_PB:    w_pos_raddr = r_cb;
            S_PC:    w_pos_raddr = r_cc;
            default: w_pos_raddr = r_ca;
        endcase
    end

    vna_ram #(.WIDTH($bits(vna_pkg::t_pos)), .DEPTH(vna_pkg::MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_pos_we),
        .i_waddr (i_vertex_index),
        .i_wdata (w_pos_wdata),
        .i_raddr (w_pos_raddr),
        .o_rdata (w_pos_rdata)
    );

    // accumulator update for one corner
    assign w_acc_sum.x = vna_pkg::sat_add(w_acc_rdata.x, r_cx);
    assign w_acc_sum.y = vna_pkg::sat_add(w_acc_rdata.y, r_cy);
    assign w_acc_sum.z = vna_pkg::sat_add(w_acc_rdata.z, r_cz);

    // accumulator ram ports: clear sweep, load clear, corner write-back
    always_comb begin
        w_acc_we    = 1'b0;
        w_acc_waddr = r_clr_idx;
        w_acc_wdata = '0;
        if (r_state == S_CLEAR) begin
            w_acc_we = 1'b1;
        end else if (w_pos_we) begin
            w_acc_we    = 1'b1;
            w_acc_waddr = i_vertex_index;
        end else if (r_state == S_AWR) begin
            w_acc_we    = 1'b1;
            w_acc_waddr = w_corner;
            w_acc_wdata = w_acc_sum;
        end
    end
    assign w_acc_raddr = (r_state == S_NRD) ? r_vi : w_corner;

    vna_ram #(.WIDTH($bits(vna_pkg::t_acc)), .DEPTH(vna_pkg::MAX_VERTICES)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_we),
        .i_waddr (w_acc_waddr),
        .i_wdata (w_acc_wdata),
        .i_raddr (w_acc_raddr),
        .o_rdata (w_acc_rdata)
    );

    // triangle edges
    assign w_e1x = EW'(r_pb.x) - EW'(r_pa.x);
    assign w_e1y = EW'(r_pb.y) - EW'(r_pa.y);
    assign w_e1z = EW'(r_pb.z) - EW'(r_pa.z);
    assign w_e2x = EW'(w_pos_rdata.x) - EW'(r_pa.x);
    assign w_e2y = EW'(w_pos_rdata.y) - EW'(r_pa.y);
    assign w_e2z = EW'(w_pos_rdata.z) - EW'(r_pa.z);

    vna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_NST),
        .i_acc   (w_acc_rdata),
        .o_done  (w_norm_done),
        .o_res   (w_norm_res)
    );

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IW'(vna_pkg::MAX_VERTICES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_vi  <= i_vertex_index;
                        r_ca  <= i_corner_a;
                        r_cb  <= i_corner_b;
                        r_cc  <= i_corner_c;
                        r_k   <= 2'd0;
                        r_err <= w_in_err;
                        r_res <= '0;
                        if (w_in_err) begin
                            r_state <= S_OUT;
                        end else if (i_op == vna_pkg::OP_TRI) begin
                            r_state <= S_PA;
                        end else if (i_op == vna_pkg::OP_READ) begin
                            r_state <= S_NRD;
                        end
                    end
                end
                S_PA:    r_state <= S_PB;
                S_PB: begin
                    r_pa    <= w_pos_rdata;
                    r_state <= S_PC;
                end
                S_PC: begin
                    r_pb    <= w_pos_rdata;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod[0] <= w_e1y * w_e2z;
                    r_prod[1] <= w_e1z * w_e2y;
                    r_prod[2] <= w_e1z * w_e2x;
                    r_prod[3] <= w_e1x * w_e2z;
                    r_prod[4] <= w_e1x * w_e2y;
                    r_prod[5] <= w_e1y * w_e2x;
                    r_state   <= S_CROSS;
                end
                S_CROSS: begin
                    r_cx    <= CW'(r_prod[0]) - CW'(r_prod[1]);
                    r_cy    <= CW'(r_prod[2]) - CW'(r_prod[3]);
                    r_cz    <= CW'(r_prod[4]) - CW'(r_prod[5]);
                    r_state <= S_ARD;
                end
                S_ARD:   r_state <= S_AWR;
                S_AWR: begin
                    r_k <= r_k + 2'd1;
                    r_state <= (r_k == 2'd2) ? S_IDLE : S_ARD;
                end
                S_NRD:   r_state <= S_NST;
                S_NST:   r_state <= S_NWAIT;
                S_NWAIT: begin
                    if (w_norm_done) begin
                        r_res   <= w_norm_res;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
            r_out       <= r_res;
            r_out_err   <= r_err;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_normal_x    = r_out.nx;
    assign o_normal_y    = r_out.ny;
    assign o_normal_z    = r_out.nz;
    assign o_degenerate  = r_out.deg;
    assign o_index_error = r_out_err;

endmodule

>>> hdl/vna_ram.sv
// generic simple dual-port ram with registered read
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/vna_norm.sv
// iterative normalizer: scale, sum of squares, square root and three divides
module vna_norm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  vna_pkg::t_acc       i_acc,
    output logic                o_done,
    output vna_pkg::t_norm_res  o_res
);

    localparam int AW = vna_pkg::ACC_BITS;
    localparam int SW = 62;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_ROOT  = 3'd3;
    localparam logic [2:0] N_DSET  = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;

    logic [2:0]     r_state;
    logic [AW-1:0]  r_m [3];
    logic           r_neg [3];
    logic [3:0]     r_cnt;
    logic [1:0]     r_k;
    logic [59:0]    r_sq;
    logic [SW-1:0]  r_sum;
    logic [SW-1:0]  r_rem;
    logic [SW-1:0]  r_root;
    logic [SW-1:0]  r_bit;
    logic [30:0]    r_len;
    logic [44:0]    r_num;
    logic [30:0]    r_drem;
    logic [15:0]    r_q;
    logic signed [vna_pkg::NRM_W-1:0] r_n [3];
    logic           r_deg;
    logic           r_done;

    logic [AW-1:0]  w_mx, w_my, w_mz, w_or;
    logic [29:0]    w_sel;
    logic [SW-1:0]  w_trial_root;
    logic [SW-1:0]  n_root;
    logic           w_root_take;
    logic [44:0]    w_num;
    logic [31:0]    w_dtrial;
    logic           w_qbit;
    logic [15:0]    n_q;
    logic [15:0]    w_qclamp;

    // input magnitudes
    assign w_mx = i_acc.x[AW-1] ? AW'(-i_acc.x) : AW'(i_acc.x);
    assign w_my = i_acc.y[AW-1] ? AW'(-i_acc.y) : AW'(i_acc.y);
    assign w_mz = i_acc.z[AW-1] ? AW'(-i_acc.z) : AW'(i_acc.z);
    assign w_or = r_m[0] | r_m[1] | r_m[2];

    // square operand selection
    always_comb begin
        case (r_k)
            2'd0:    w_sel = r_m[0][29:0];
            2'd1:    w_sel = r_m[1][29:0];
            2'd2:    w_sel = r_m[2][29:0];
            default: w_sel = '0;
        endcase
    end

    // one digit of the square root
    assign w_trial_root = r_root + r_bit;
    assign w_root_take  = (r_rem >= w_trial_root);
    assign n_root       = w_root_take ? ((r_root >> 1) + r_bit) : (r_root >> 1);

    // one quotient bit of the divide
    assign w_num    = {1'b0, w_sel, 14'd0} + 45'(r_len >> 1);
    assign w_dtrial = {r_drem, r_num[15]};
    assign w_qbit   = (w_dtrial >= {1'b0, r_len});
    assign n_q      = {r_q[14:0], w_qbit};
    assign w_qclamp = (n_q > 16'd16384) ? 16'd16384 : n_q;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_m[0]   <= w_mx;
                        r_m[1]   <= w_my;
                        r_m[2]   <= w_mz;
                        r_neg[0] <= i_acc.x[AW-1];
                        r_neg[1] <= i_acc.y[AW-1];
                        r_neg[2] <= i_acc.z[AW-1];
                        if ((w_mx | w_my | w_mz) == '0) begin
                            r_n[0] <= '0;
                            r_n[1] <= '0;
                            r_n[2] <= '0;
                            r_deg  <= 1'b1;
                            r_done <= 1'b1;
                        end else begin
                            r_deg   <= 1'b0;
                            r_state <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT: begin
                    if (|w_or[AW-1:30]) begin
                        r_m[0] <= r_m[0] >> 1;
                        r_m[1] <= r_m[1] >> 1;
                        r_m[2] <= r_m[2] >> 1;
                    end else if (!w_or[29]) begin
                        r_m[0] <= r_m[0] << 1;
                        r_m[1] <= r_m[1] << 1;
                        r_m[2] <= r_m[2] << 1;
                    end else begin
                        r_k     <= 2'd0;
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    // square then accumulate, one component per cycle
                    r_sq <= w_sel * w_sel;
                    r_k  <= r_k + 2'd1;
                    if (r_cnt == 4'd3) begin
                        r_rem   <= r_sum + SW'(r_sq);
                        r_root  <= '0;
                        r_bit   <= SW'(1) << 60;
                        r_state <= N_ROOT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                        if (r_cnt != 4'd0) begin
                            r_sum <= r_sum + SW'(r_sq);
                        end
                    end
                end
                N_ROOT: begin
                    if (w_root_take) begin
                        r_rem <= r_rem - w_trial_root;
                    end
                    r_root <= n_root;
                    r_bit  <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_len   <= n_root[30:0];
                        r_k     <= 2'd0;
                        r_state <= N_DSET;
                    end
                end
                N_DSET: begin
                    r_num   <= w_num;
                    r_drem  <= {2'b00, w_num[44:16]};
                    r_cnt   <= '0;
                    r_q     <= '0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    if (w_qbit) begin
                        r_drem <= 31'(w_dtrial - {1'b0, r_len});
                    end else begin
                        r_drem <= w_dtrial[30:0];
                    end
                    r_num <= r_num << 1;
                    r_q   <= n_q;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_n[r_k] <= r_neg[r_k] ? -$signed(w_qclamp) : $signed(w_qclamp);
                        if (r_k == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= N_IDLE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= N_DSET;
                        end
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_res.nx  = r_n[0];
    assign o_res.ny  = r_n[1];
    assign o_res.nz  = r_n[2];
    assign o_res.deg = r_deg;

endmodule

>>> test/testbench.sv
// self-checking testbench for the vertex normal accumulator
`timescale 1ns / 100ps

module testbench;

    localparam int IW = vna_pkg::IDX_W;
    localparam int PW = vna_pkg::POS_W;
    localparam int NW = vna_pkg::NRM_W;
    localparam int NV = vna_pkg::MAX_VERTICES;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1750;

    typedef struct {
        logic [1:0]           op;
        logic [IW-1:0]        vidx;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [PW-1:0] pz;
        logic [IW-1:0]        ca;
        logic [IW-1:0]        cb;
        logic [IW-1:0]        cc;
    } t_item;

    typedef struct {
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic                 deg;
        logic                 err;
    } t_normal;

    typedef struct {
        t_item   it;
        logic    typed;
        t_normal want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [1:0] i_op = vna_pkg::OP_LOAD;
    logic [IW-1:0] i_vertex_index = '0;
    logic signed [PW-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [IW-1:0] i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [NW-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_degenerate, o_index_error;

    // shadow state of the block
    longint vtx_pos [NV][3];
    longint face_sum [NV][3];
    bit     was_loaded [NV];
    int     loaded_list[$];

    t_normal pending_normals[$];
    t_stim_row directed_rows[$];
    int  fail_count = 0;
    int  cycle_count = 0;
    int  hold_request = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    bit  sender_calm = 1'b0;

    vertex_normal_accumulator u_top (.*);

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint clamp_acc(input longint acc, input longint c);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (vna_pkg::ACC_BITS - 1)) - 1;
        lo = -hi - 1;
        if (c > 0 && acc > hi - c) return hi;
        if (c < 0 && acc < lo - c) return lo;
        return acc + c;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // unit normal of one accumulator in Q1.14
    function automatic t_normal unit_normal(input int v);
        t_normal res;
        longint unsigned mag [3];
        longint unsigned top;
        longint unsigned total;
        longint unsigned len;
        longint unsigned q;
        int p;
        res = '{0, 0, 0, 1'b0, 1'b0};
        for (int i = 0; i < 3; i++)
            mag[i] = face_sum[v][i] < 0 ? -face_sum[v][i] : face_sum[v][i];
        top = mag[0];
        if (mag[1] > top) top = mag[1];
        if (mag[2] > top) top = mag[2];
        if (top == 0) begin
            res.deg = 1'b1;
            return res;
        end
        p = 63;
        while (top[p] == 1'b0) p--;
        total = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (p > 29) ? (mag[i] >> (p - 29)) : (mag[i] << (29 - p));
            total += mag[i] * mag[i];
        end
        len = int_sqrt(total);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 14) + (len >> 1)) / len;
            if (q > 16384) q = 16384;
            if (i == 0) res.nx = NW'(face_sum[v][i] < 0 ? -q : q);
            if (i == 1) res.ny = NW'(face_sum[v][i] < 0 ? -q : q);
            if (i == 2) res.nz = NW'(face_sum[v][i] < 0 ? -q : q);
        end
        return res;
    endfunction

    // apply one accepted beat to the shadow state, returns 1 when a result is due
    function automatic bit apply_item(input t_item it, output t_normal res);
        longint e1 [3];
        longint e2 [3];
        longint cr [3];
        int corner [3];
        res = '{0, 0, 0, 1'b0, 1'b0};
        case (it.op)
            vna_pkg::OP_LOAD: begin
                if (vna_pkg::idx_bad(it.vidx)) begin
                    res.err = 1'b1;
                    return 1'b1;
                end
                vtx_pos[it.vidx][0] = it.px;
                vtx_pos[it.vidx][1] = it.py;
                vtx_pos[it.vidx][2] = it.pz;
                for (int i = 0; i < 3; i++) face_sum[it.vidx][i] = 0;
                if (!was_loaded[it.vidx]) begin
                    was_loaded[it.vidx] = 1'b1;
                    loaded_list = {loaded_list, int'(it.vidx)};
                end
                return 1'b0;
            end
            vna_pkg::OP_TRI: begin
                if (vna_pkg::idx_bad(it.ca) || vna_pkg::idx_bad(it.cb)
                    || vna_pkg::idx_bad(it.cc)) begin
                    res.err = 1'b1;
                    return 1'b1;
                end
                for (int i = 0; i < 3; i++) begin
                    e1[i] = vtx_pos[it.cb][i] - vtx_pos[it.ca][i];
                    e2[i] = vtx_pos[it.cc][i] - vtx_pos[it.ca][i];
                end
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                corner = '{int'(it.ca), int'(it.cb), int'(it.cc)};
                foreach (corner[k])
                    for (int i = 0; i < 3; i++)
                        face_sum[corner[k]][i] = clamp_acc(face_sum[corner[k]][i], cr[i]);
                return 1'b0;
            end
            vna_pkg::OP_READ: begin
                if (vna_pkg::idx_bad(it.vidx)) begin
                    res.err = 1'b1;
                    return 1'b1;
                end
                res = unit_normal(int'(it.vidx));
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // offer one beat and wait for it to be taken
    task automatic send_beat(input t_item it, input bit typed, input t_normal want);
        t_normal res;
        bit due;
        int gap;
        if (!sender_calm && $urandom_range(0, 99) < 21) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= it.op;
        i_vertex_index <= it.vidx;
        i_pos_x        <= it.px;
        i_pos_y        <= it.py;
        i_pos_z        <= it.pz;
        i_corner_a     <= it.ca;
        i_corner_b     <= it.cb;
        i_corner_c     <= it.cc;
        do @(posedge i_clk); while (!o_in_ready);
        due = apply_item(it, res);
        if (due) pending_normals = {pending_normals, typed ? want : res};
    endtask

    // stop offering and wait until every expected result has come
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_item make_item(input logic [1:0] op, input int vidx,
                                        input int px, input int py, input int pz,
                                        input int ca, input int cb, input int cc);
        t_item it;
        it.op   = op;
        it.vidx = IW'(vidx);
        it.px   = PW'(px);
        it.py   = PW'(py);
        it.pz   = PW'(pz);
        it.ca   = IW'(ca);
        it.cb   = IW'(cb);
        it.cc   = IW'(cc);
        return it;
    endfunction

    function automatic void add_row(input t_item it, input bit typed, input t_normal want);
        t_stim_row row;
        row = '{it, typed, want};
        directed_rows = {directed_rows, row};
    endfunction

    function automatic int pick_index();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, NV - 1)
                                           : $urandom_range(0, 47);
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    // receiver: random stalls outside a window of the run, plus a long hold on each request
    always @(posedge i_clk) begin
        if (hold_seen != hold_request) begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (cycle_count > 40000 && cycle_count < 70000) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 21);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_normal w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_normals.size() == 0) begin
                $display("%0t unexpected result beat: %0d %0d %0d deg %b err %b", $time,
                         o_normal_x, o_normal_y, o_normal_z, o_degenerate, o_index_error);
                fail_count++;
            end else begin
                w = pending_normals.pop_front();
                if (o_normal_x !== w.nx) begin
                    $display("%0t normal_x expected %0d got %0d", $time, w.nx, o_normal_x);
                    fail_count++;
                end
                if (o_normal_y !== w.ny) begin
                    $display("%0t normal_y expected %0d got %0d", $time, w.ny, o_normal_y);
                    fail_count++;
                end
                if (o_normal_z !== w.nz) begin
                    $display("%0t normal_z expected %0d got %0d", $time, w.nz, o_normal_z);
                    fail_count++;
                end
                if (o_degenerate !== w.deg) begin
                    $display("%0t degenerate expected %b got %b", $time, w.deg, o_degenerate);
                    fail_count++;
                end
                if (o_index_error !== w.err) begin
                    $display("%0t index_error expected %b got %b", $time, w.err,
                             o_index_error);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_normal none;
        t_normal flat;
        t_normal up;
        t_item it;
        int sel;
        int count;
        int base;
        none = '{0, 0, 0, 1'b0, 1'b0};
        flat = '{0, 0, 0, 1'b1, 1'b0};
        up   = '{0, 0, 16384, 1'b0, 1'b0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: zero accumulators, an axis normal, cancel, extremes
        add_row(make_item(vna_pkg::OP_READ, 5, 0, 0, 0, 0, 0, 0), 1, flat);
        add_row(make_item(vna_pkg::OP_LOAD, 10, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_item(vna_pkg::OP_LOAD, 11, 256, 0, 0, 0, 0, 0), 0, none);
        add_row(make_item(vna_pkg::OP_LOAD, 12, 0, 256, 0, 0, 0, 0), 0, none);
        add_row(make_item(vna_pkg::OP_TRI, 0, 0, 0, 0, 10, 11, 12), 0, none);
        add_row(make_item(vna_pkg::OP_READ, 10, 0, 0, 0, 0, 0, 0), 1, up);
        add_row(make_item(vna_pkg::OP_READ, 11, 0, 0, 0, 0, 0, 0), 1, up);
        add_row(make_item(vna_pkg::OP_TRI, 0, 0, 0, 0, 10, 12, 11), 0, none);
        add_row(make_item(vna_pkg::OP_READ, 12, 0, 0, 0, 0, 0, 0), 1, flat);
        add_row(make_item(vna_pkg::OP_LOAD, 0, -32768, -32768, -32768, 0, 0, 0), 0, none);
        add_row(make_item(vna_pkg::OP_LOAD, 1023, 32767, 32767, 32767, 0, 0, 0), 0, none);
        add_row(make_item(vna_pkg::OP_LOAD, 1, 32767, -32768, 0, 0, 0, 0), 0, none);
        add_row(make_item(vna_pkg::OP_TRI, 0, 0, 0, 0, 0, 1, 1023), 0, none);
        add_row(make_item(vna_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_item(OP_NONE, 1023, -1, -1, -1, 1023, 1023, 1023), 0, none);
        add_row(make_item(vna_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_item(vna_pkg::OP_LOAD, 11, 1, 1, 1, 0, 0, 0), 0, none);
        add_row(make_item(vna_pkg::OP_READ, 11, 0, 0, 0, 0, 0, 0), 1, flat);
        add_row(make_item(vna_pkg::OP_TRI, 0, 0, 0, 0, 1023, 1023, 1023), 0, none);
        add_row(make_item(vna_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_item(vna_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0), 0, none);
        foreach (directed_rows[r])
            send_beat(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].want);

        // random mix with saturation bursts on a large triangle
        count = 0;
        while (count < RANDOM_ITEMS) begin
            sender_calm = (count > 300 && count < 550);
            if (count == 800) hold_request++;
            if (count % 450 == 449) begin
                wait_drained();
                base = $urandom_range(100, 1020);
                send_beat(make_item(vna_pkg::OP_LOAD, base, -32768, -32768,
                                    $urandom_range(0, 65535), 0, 0, 0), 0, none);
                send_beat(make_item(vna_pkg::OP_LOAD, base + 1, 32767, -32768, -32768,
                                    0, 0, 0), 0, none);
                send_beat(make_item(vna_pkg::OP_LOAD, base + 2, -32768, 32767, 32767,
                                    0, 0, 0), 0, none);
                repeat (140) send_beat(make_item(vna_pkg::OP_TRI, 0, 0, 0, 0, base,
                                                 base + 1, base + 2), 0, none);
                for (int k = 0; k < 3; k++)
                    send_beat(make_item(vna_pkg::OP_READ, base + k, 0, 0, 0, 0, 0, 0),
                              0, none);
                count += 146;
            end
            it = make_item(OP_NONE, pick_index(), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 1023));
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                it.op = vna_pkg::OP_LOAD;
            end else if (sel < 70) begin
                it.op = vna_pkg::OP_TRI;
                it.ca = IW'(pick_loaded());
                it.cb = IW'(pick_loaded());
                it.cc = IW'(pick_loaded());
            end else if (sel < 95) begin
                it.op = vna_pkg::OP_READ;
            end
            send_beat(it, 0, none);
            if (it.op != OP_NONE) count++;
        end
        i_in_valid <= 1'b0;

        // drain and let the block settle
        wait_drained();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
